/* src/plq_pkg.sv */
`default_nettype none
package plq_pkg;

   // Width of the register index on the configuration channel.
   localparam int CsrIdxBits = 3;

   // Register map of the configuration channel.
   typedef enum logic [CsrIdxBits-1:0] {
      CSR_NORMAL_X = 3'd0,
      CSR_NORMAL_Y = 3'd1,
      CSR_NORMAL_Z = 3'd2,
      CSR_ANCHOR_X = 3'd3,
      CSR_ANCHOR_Y = 3'd4,
      CSR_ANCHOR_Z = 3'd5
   } csr_index_type;

endpackage
`default_nettype wire

/* src/plq_if.sv */
`default_nettype none
// Request channel: the two points of one line.
interface plq_req_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] p1_x;
   logic signed [COORD_BITS-1:0] p1_y;
   logic signed [COORD_BITS-1:0] p1_z;
   logic signed [COORD_BITS-1:0] p2_x;
   logic signed [COORD_BITS-1:0] p2_y;
   logic signed [COORD_BITS-1:0] p2_z;
   modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, input ready);
   modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, output ready);
endinterface

// Response channel: intercept and side flags.
interface plq_rsp_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] hit_x;
   logic signed [COORD_BITS-1:0] hit_y;
   logic signed [COORD_BITS-1:0] hit_z;
   logic                         parallel;
   logic                         clipped;
   logic                         same_side;
   logic                         on_plane;
   modport source (output valid, hit_x, hit_y, hit_z, parallel, clipped, same_side,
                   on_plane, input ready);
   modport sink (input valid, hit_x, hit_y, hit_z, parallel, clipped, same_side,
                 on_plane, output ready);
endinterface

// Configuration write channel.
interface plq_csr_if #(parameter int COORD_BITS = 32);
   logic                                  valid;
   logic                                  ready;
   logic [plq_pkg::CsrIdxBits-1:0]        index;
   logic signed [COORD_BITS-1:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/plane_line_query.sv */
// Line/plane intersection pipeline. Each request carries two points p1 and p2; the
// plane is set through the configuration channel as a normal and an anchor point.
// The response gives the point where the line from p1 through p2 meets the plane
// (truncated toward zero, saturated to the coordinate range, with clipped set when
// saturation occurred), a parallel flag with p1 returned when the direction is
// parallel to the plane, and the same_side and on_plane tests. One request is taken
// every cycle while the response is not stalled; a stalled response holds the whole
// pipeline. The divider resolves one quotient bit per pipeline stage. Configuration
// is written while the pipeline is empty: the user must keep to this, as the block
// itself does not enforce it, and its configuration channel is always ready.
`default_nettype none
module plane_line_query #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire          clock,
   input  wire          reset,
   plq_req_if.sink      req_chan,
   plq_rsp_if.source    rsp_chan,
   plq_csr_if.sink      csr_chan
);

   localparam int DFW = COORD_BITS + 1;       // coordinate difference
   localparam int PW  = DFW + COORD_BITS;     // difference times normal
   localparam int SW  = PW + 2;               // side value
   localparam int DW  = SW + 1;               // denominator
   localparam int SLO = COORD_BITS + 2;       // low split of the side value
   localparam int SHI = SW - SLO;
   localparam int PLW = DFW + SLO + 1;
   localparam int PHW = DFW + SHI;
   localparam int NW  = DFW + SW;             // numerator
   localparam int QB  = COORD_BITS + 2;       // quotient bits, top one flags overflow
   localparam int CW  = DW + QB - 1;          // divider compare width
   localparam int HW  = COORD_BITS + 4;       // hit sum width
   localparam logic signed [HW-1:0] HMAX = HW'({1'b0, {(COORD_BITS-1){1'b1}}});
   localparam logic signed [HW-1:0] HMIN = -HMAX - HW'(1);

   typedef struct packed {
      logic [2:0][COORD_BITS-1:0] p1;
      logic [2:0]                 neg;
      logic                       parallel;
      logic                       same_side;
      logic                       on_plane;
   } carry_type;

   // Pipeline advance: everything moves unless a finished response is stalled.
   logic adv;
   logic rsp_vld_ff;
   assign adv = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign csr_chan.ready = 1'b1;

   // Plane registers.
   logic signed [COORD_BITS-1:0] nrm_ff [3];
   logic signed [COORD_BITS-1:0] anc_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         nrm_ff[0] <= '0;
         nrm_ff[1] <= '0;
         nrm_ff[2] <= COORD_BITS'(64'd1 << FRAC_BITS);
         anc_ff[0] <= '0;
         anc_ff[1] <= '0;
         anc_ff[2] <= '0;
      end else if (csr_chan.valid) begin
         unique case (plq_pkg::csr_index_type'(csr_chan.index))
            plq_pkg::CSR_NORMAL_X: nrm_ff[0] <= csr_chan.data;
            plq_pkg::CSR_NORMAL_Y: nrm_ff[1] <= csr_chan.data;
            plq_pkg::CSR_NORMAL_Z: nrm_ff[2] <= csr_chan.data;
            plq_pkg::CSR_ANCHOR_X: anc_ff[0] <= csr_chan.data;
            plq_pkg::CSR_ANCHOR_Y: anc_ff[1] <= csr_chan.data;
            plq_pkg::CSR_ANCHOR_Z: anc_ff[2] <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Valid bits for the front stages, the divider stages and the response.
   logic [5:1] v_ff;
   logic [QB:0] dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         dv_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         v_ff  <= {v_ff[4:1], req_chan.valid};
         dv_ff <= {dv_ff[QB-1:0], v_ff[5]};
         rsp_vld_ff <= dv_ff[QB];
      end
   end

   // Stage 1: differences against the anchor and the line direction.
   logic signed [COORD_BITS-1:0] p1_w [3];
   logic signed [COORD_BITS-1:0] p2_w [3];
   logic signed [DFW-1:0] a1_ff [3];
   logic signed [DFW-1:0] a2_ff [3];
   logic signed [DFW-1:0] d1_ff [3];
   logic signed [COORD_BITS-1:0] p1s1_ff [3];

   assign p1_w[0] = req_chan.p1_x;
   assign p1_w[1] = req_chan.p1_y;
   assign p1_w[2] = req_chan.p1_z;
   assign p2_w[0] = req_chan.p2_x;
   assign p2_w[1] = req_chan.p2_y;
   assign p2_w[2] = req_chan.p2_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            a1_ff[i]   <= DFW'(anc_ff[i]) - DFW'(p1_w[i]);
            a2_ff[i]   <= DFW'(anc_ff[i]) - DFW'(p2_w[i]);
            d1_ff[i]   <= DFW'(p2_w[i]) - DFW'(p1_w[i]);
            p1s1_ff[i] <= p1_w[i];
         end
      end
   end

   // Stage 2: per-axis products with the normal.
   logic signed [PW-1:0] m1_ff [3];
   logic signed [PW-1:0] m2_ff [3];
   logic signed [DFW-1:0] d2_ff [3];
   logic signed [COORD_BITS-1:0] p1s2_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            m1_ff[i]   <= a1_ff[i] * nrm_ff[i];
            m2_ff[i]   <= a2_ff[i] * nrm_ff[i];
            d2_ff[i]   <= d1_ff[i];
            p1s2_ff[i] <= p1s1_ff[i];
         end
      end
   end

   // Stage 3: side values of both points.
   logic signed [SW-1:0] s1_ff;
   logic signed [SW-1:0] s2_ff;
   logic signed [DFW-1:0] d3_ff [3];
   logic signed [COORD_BITS-1:0] p1s3_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= SW'(m1_ff[0]) + SW'(m1_ff[1]) + SW'(m1_ff[2]);
         s2_ff <= SW'(m2_ff[0]) + SW'(m2_ff[1]) + SW'(m2_ff[2]);
         for (int i = 0; i < 3; i++) begin
            d3_ff[i]   <= d2_ff[i];
            p1s3_ff[i] <= p1s2_ff[i];
         end
      end
   end

   // Stage 4: denominator, side flags and split numerator products.
   logic signed [DW-1:0]  den4_ff;
   logic signed [PLW-1:0] pl_ff [3];
   logic signed [PHW-1:0] ph_ff [3];
   logic same4_ff;
   logic onp4_ff;
   logic signed [COORD_BITS-1:0] p1s4_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         den4_ff  <= DW'(s1_ff) - DW'(s2_ff);
         onp4_ff  <= (s1_ff == '0);
         same4_ff <= (s1_ff[SW-1] && s2_ff[SW-1]) ||
                     (!s1_ff[SW-1] && s1_ff != '0 && !s2_ff[SW-1] && s2_ff != '0);
         for (int i = 0; i < 3; i++) begin
            pl_ff[i]   <= d3_ff[i] * $signed({1'b0, s1_ff[SLO-1:0]});
            ph_ff[i]   <= d3_ff[i] * $signed(s1_ff[SW-1:SLO]);
            p1s4_ff[i] <= p1s3_ff[i];
         end
      end
   end

   // Stage 5: full numerators and the parallel test.
   logic signed [NW-1:0] num5_ff [3];
   logic signed [DW-1:0] den5_ff;
   logic par5_ff;
   logic same5_ff;
   logic onp5_ff;
   logic signed [COORD_BITS-1:0] p1s5_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            num5_ff[i] <= (NW'(ph_ff[i]) <<< SLO) + NW'(pl_ff[i]);
            p1s5_ff[i] <= p1s4_ff[i];
         end
         den5_ff  <= den4_ff;
         par5_ff  <= (den4_ff == '0);
         same5_ff <= same4_ff;
         onp5_ff  <= onp4_ff;
      end
   end

   // Stage 6 and divider stages: magnitudes, then one quotient bit per stage.
   logic [NW-1:0] rem_ff [QB+1][3];
   logic [QB-1:0] quo_ff [QB+1][3];
   logic [DW-1:0] dd_ff  [QB+1];
   carry_type     cr_ff  [QB+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i]     <= num5_ff[i][NW-1] ? NW'(-num5_ff[i]) : NW'(num5_ff[i]);
            quo_ff[0][i]     <= '0;
            cr_ff[0].p1[i]   <= p1s5_ff[i];
            cr_ff[0].neg[i]  <= num5_ff[i][NW-1] ^ den5_ff[DW-1];
         end
         dd_ff[0]           <= den5_ff[DW-1] ? DW'(-den5_ff) : DW'(den5_ff);
         cr_ff[0].parallel  <= par5_ff;
         cr_ff[0].same_side <= same5_ff;
         cr_ff[0].on_plane  <= onp5_ff;
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int K = QB - 1 - j;
      logic [CW-1:0] sub_w;
      logic [2:0]    ge_w;
      logic [CW-1:0] diff_w [3];

      // Restoring step against the denominator shifted to this bit.
      always_comb begin
         sub_w = CW'(dd_ff[j]) << K;
         for (int i = 0; i < 3; i++) begin
            ge_w[i]   = CW'(rem_ff[j][i]) >= sub_w;
            diff_w[i] = CW'(rem_ff[j][i]) - sub_w;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[j+1][i] <= ge_w[i] ? NW'(diff_w[i]) : rem_ff[j][i];
               quo_ff[j+1][i] <= quo_ff[j][i] | (QB'(ge_w[i]) << K);
            end
            dd_ff[j+1] <= dd_ff[j];
            cr_ff[j+1] <= cr_ff[j];
         end
      end
   end

   // Final stage: sign, add the source point, saturate.
   logic signed [HW-1:0] hit_w [3];
   logic [2:0]           clip_w;
   logic [QB-1:0]        mag_w [3];
   logic signed [HW-1:0] qs_w [3];
   logic signed [HW-1:0] sum_w [3];
   carry_type            cq_w;

   assign cq_w = cr_ff[QB];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_w[i] = quo_ff[QB][i][QB-1] ? (QB'(1) << (QB - 1)) : quo_ff[QB][i];
         qs_w[i]  = cq_w.neg[i] ? -$signed(HW'(mag_w[i])) : $signed(HW'(mag_w[i]));
         sum_w[i] = HW'($signed(cq_w.p1[i])) + qs_w[i];
         clip_w[i] = 1'b0;
         if (cq_w.parallel) begin
            hit_w[i] = HW'($signed(cq_w.p1[i]));
         end else if (sum_w[i] > HMAX) begin
            hit_w[i] = HMAX;
            clip_w[i] = 1'b1;
         end else if (sum_w[i] < HMIN) begin
            hit_w[i] = HMIN;
            clip_w[i] = 1'b1;
         end else begin
            hit_w[i] = sum_w[i];
         end
      end
   end

   // Response register.
   logic signed [COORD_BITS-1:0] hit_ff [3];
   logic par_ff;
   logic clip_ff;
   logic same_ff;
   logic onp_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            hit_ff[i] <= COORD_BITS'(hit_w[i]);
         end
         par_ff  <= cq_w.parallel;
         clip_ff <= |clip_w;
         same_ff <= cq_w.same_side;
         onp_ff  <= cq_w.on_plane;
      end
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.hit_x     = hit_ff[0];
   assign rsp_chan.hit_y     = hit_ff[1];
   assign rsp_chan.hit_z     = hit_ff[2];
   assign rsp_chan.parallel  = par_ff;
   assign rsp_chan.clipped   = clip_ff;
   assign rsp_chan.same_side = same_ff;
   assign rsp_chan.on_plane  = onp_ff;

   // A parallel line is never reported as saturated.
   a_par_noclip: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && par_ff |-> !clip_ff)
      else $error("parallel response reported as clipped");

   // A point on the plane cannot be strictly on one side.
   a_onp_side: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && onp_ff |-> !same_ff)
      else $error("on_plane and same_side both set");

   // A stalled response keeps the pipeline occupancy unchanged.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_chan.ready |=> $stable(dv_ff) && $stable(v_ff))
      else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
